// ===== rtl/llrb_pkg.sv =====
package llrb_pkg;

  // command codes of an input item
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  // status codes of a result item
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BYTE     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [7:0] NEWLINE = 8'h0A;

  // result queue geometry
  localparam int QUEUE_DEPTH = 3;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // result of one item, as it waits in the output queue
  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } item_t;

  // control carried from the update stage to the result stage
  typedef struct packed {
    status_t status;
    logic    last;
  } pend_t;

endpackage

// ===== rtl/llrb_ram.sv =====
module llrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== rtl/llrb_out_fifo.sv =====
module llrb_out_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  llrb_pkg::item_t          push_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output llrb_pkg::item_t          out_item,
  output logic [llrb_pkg::CW-1:0]  count
);

  llrb_pkg::item_t             mem_r [llrb_pkg::QUEUE_DEPTH];
  logic [llrb_pkg::QW-1:0]     head_r, head_nxt;
  logic [llrb_pkg::QW-1:0]     tail_r, tail_nxt;
  logic [llrb_pkg::CW-1:0]     count_r, count_nxt;
  logic                        pop;

  localparam logic [llrb_pkg::QW-1:0] LAST_IDX = llrb_pkg::QW'(llrb_pkg::QUEUE_DEPTH - 1);

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[head_r];
  assign count     = count_r;
  assign pop       = out_valid & ~out_stall;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
    if (push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_item;
    end
  end

endmodule

// ===== rtl/last_lines_ring_buffer_top.sv =====
// last-lines ring buffer: keeps the most recent tail_lines complete lines
// (newline terminated) of a byte stream and hands them back one byte per
// read item, oldest line first, with is_last on the final byte; a partial
// line at the end is never handed out. text lives in a BUFFER_BYTES byte
// ram, line start positions in a ram of TAIL_MAX+1 entries, and the start
// of the oldest and of the newest line are also kept in registers so that
// every item touches each ram at one address only. an item of any kind is
// taken every cycle while in_stall is low: the state is updated in the
// accept cycle, the registered byte ram read completes in the next cycle,
// and the result goes into a three-entry output queue, so up to three
// results wait out a stalled output before in_stall rises. a write that
// would run into the oldest kept byte sets a sticky overflow that answers
// every write and read with the overflow status until a restart item, a
// tail_lines write or reset. writing tail_lines (clamped to TAIL_MAX)
// empties the buffer as a restart does; the user must write it only while
// no item is in flight, and the block does not enforce this. the rams are
// never cleared: nothing reads an entry that has not been written since the last restart
module last_lines_ring_buffer_top #(
  parameter int BUFFER_BYTES = 1024,
  parameter int TAIL_MAX     = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // item input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_is_last
);

  localparam int PW          = $clog2(BUFFER_BYTES);
  localparam int LINE_DEPTH  = TAIL_MAX + 1;
  localparam int LW          = $clog2(LINE_DEPTH);
  localparam int RESET_LINES = (TAIL_MAX < 10) ? TAIL_MAX : 10;
  localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_BYTES - 1);

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  // line ring holds n_eff+1 entries
  function automatic logic [LW-1:0] next_line(input logic [LW-1:0] i,
                                              input logic [LW-1:0] last);
    return (i == last) ? '0 : i + 1'b1;
  endfunction

  // architectural state
  logic [LW-1:0] n_eff_r, n_eff_nxt;
  logic [PW-1:0] write_pos_r, write_pos_nxt;
  logic [PW-1:0] read_pos_r, read_pos_nxt;
  logic [LW-1:0] newest_line_r, newest_line_nxt;
  logic [LW-1:0] oldest_line_r, oldest_line_nxt;
  logic [PW-1:0] oldest_start_r, oldest_start_nxt;  // line_starts[oldest_line]
  logic [PW-1:0] newest_start_r, newest_start_nxt;  // line_starts[newest_line]
  logic          draining_r, draining_nxt;
  logic          ovf_r, ovf_nxt;

  // line start ram prefetch and forwarding
  logic [LW-1:0] ls_raddr_r, ls_raddr_nxt;
  logic [PW-1:0] ls_rdata;
  logic [PW-1:0] ls_ahead;        // line_starts[next(oldest_line)]
  logic          lw_valid_r;
  logic [LW-1:0] lw_addr_r;
  logic [PW-1:0] lw_data_r;
  logic          line_we;

  // byte ram
  logic          byte_we;
  logic [PW-1:0] byte_raddr;
  logic [7:0]    byte_rdata;

  // update step
  logic          in_accept;
  logic [PW-1:0] wp_adv;
  logic [LW-1:0] nl;
  logic [PW-1:0] rp;
  logic [PW-1:0] rp_adv;
  llrb_pkg::pend_t res;

  // result stage
  logic            p1_valid_r;
  llrb_pkg::pend_t p1_r;
  llrb_pkg::item_t push_item;
  llrb_pkg::item_t out_item;
  logic [llrb_pkg::CW-1:0] q_count;
  logic [llrb_pkg::CW:0]   inflight;

  // one item in flight per queue slot
  assign inflight  = {1'b0, q_count} + (llrb_pkg::CW+1)'(p1_valid_r);
  assign in_stall  = (inflight >= (llrb_pkg::CW+1)'(llrb_pkg::QUEUE_DEPTH));
  assign in_accept = in_valid & ~in_stall;

  assign wp_adv = next_pos(write_pos_r);
  assign nl     = next_line(newest_line_r, n_eff_r);
  // first read after a write or restart starts at the oldest kept line
  assign rp     = draining_r ? read_pos_r : oldest_start_r;
  assign rp_adv = next_pos(rp);
  assign byte_raddr = rp;

  // last cycle's line write is not yet visible at the ram output
  assign ls_ahead = (lw_valid_r && (lw_addr_r == ls_raddr_r)) ? lw_data_r : ls_rdata;

  always_comb begin
    n_eff_nxt        = n_eff_r;
    write_pos_nxt    = write_pos_r;
    read_pos_nxt     = read_pos_r;
    newest_line_nxt  = newest_line_r;
    oldest_line_nxt  = oldest_line_r;
    oldest_start_nxt = oldest_start_r;
    newest_start_nxt = newest_start_r;
    draining_nxt     = draining_r;
    ovf_nxt          = ovf_r;
    byte_we          = 1'b0;
    line_we          = 1'b0;
    res.status       = llrb_pkg::ST_ACCEPTED;
    res.last         = 1'b0;

    if (cfg_wr_en) begin
      // register write empties the buffer
      n_eff_nxt = (int'(cfg_wr_data) > TAIL_MAX) ? LW'(TAIL_MAX) : LW'(cfg_wr_data);
      write_pos_nxt    = '0;
      read_pos_nxt     = '0;
      newest_line_nxt  = '0;
      oldest_line_nxt  = '0;
      oldest_start_nxt = '0;
      newest_start_nxt = '0;
      draining_nxt     = 1'b0;
      ovf_nxt          = 1'b0;
    end else if (in_accept) begin
      unique case (in_opcode)
        llrb_pkg::OP_WRITE: begin
          if (ovf_r) begin
            res.status = llrb_pkg::ST_OVERFLOW;
          end else begin
            draining_nxt = 1'b0;
            byte_we      = 1'b1;
            if (wp_adv == oldest_start_r) begin
              // would wrap onto the oldest kept byte
              ovf_nxt    = 1'b1;
              res.status = llrb_pkg::ST_OVERFLOW;
            end else begin
              write_pos_nxt = wp_adv;
              if (in_data_byte == llrb_pkg::NEWLINE) begin
                line_we          = 1'b1;
                newest_line_nxt  = nl;
                newest_start_nxt = wp_adv;
                if (nl == oldest_line_r) begin
                  // ring full, drop the oldest line
                  oldest_line_nxt  = next_line(oldest_line_r, n_eff_r);
                  // with a one-entry ring the dropped entry is the one written now
                  oldest_start_nxt = (n_eff_r == '0) ? wp_adv : ls_ahead;
                end
              end
            end
          end
        end
        llrb_pkg::OP_READ: begin
          if (ovf_r) begin
            res.status = llrb_pkg::ST_OVERFLOW;
          end else begin
            draining_nxt = 1'b1;
            if (rp == newest_start_r) begin
              read_pos_nxt = rp;
              res.status   = llrb_pkg::ST_EMPTY;
            end else begin
              read_pos_nxt = rp_adv;
              res.status   = llrb_pkg::ST_BYTE;
              res.last     = (rp_adv == newest_start_r);
            end
          end
        end
        llrb_pkg::OP_RESTART: begin
          write_pos_nxt    = '0;
          read_pos_nxt     = '0;
          newest_line_nxt  = '0;
          oldest_line_nxt  = '0;
          oldest_start_nxt = '0;
          newest_start_nxt = '0;
          draining_nxt     = 1'b0;
          ovf_nxt          = 1'b0;
        end
        default: begin
          res.status = llrb_pkg::ST_ACCEPTED;
        end
      endcase
    end

    // keep the entry after the oldest line staged at the ram output
    ls_raddr_nxt = next_line(oldest_line_nxt, n_eff_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r        <= LW'(RESET_LINES);
      write_pos_r    <= '0;
      read_pos_r     <= '0;
      newest_line_r  <= '0;
      oldest_line_r  <= '0;
      oldest_start_r <= '0;
      newest_start_r <= '0;
      draining_r     <= 1'b0;
      ovf_r          <= 1'b0;
      ls_raddr_r     <= next_line('0, LW'(RESET_LINES));
      lw_valid_r     <= 1'b0;
      p1_valid_r     <= 1'b0;
    end else begin
      n_eff_r        <= n_eff_nxt;
      write_pos_r    <= write_pos_nxt;
      read_pos_r     <= read_pos_nxt;
      newest_line_r  <= newest_line_nxt;
      oldest_line_r  <= oldest_line_nxt;
      oldest_start_r <= oldest_start_nxt;
      newest_start_r <= newest_start_nxt;
      draining_r     <= draining_nxt;
      ovf_r          <= ovf_nxt;
      ls_raddr_r     <= ls_raddr_nxt;
      lw_valid_r     <= line_we;
      p1_valid_r     <= in_accept & ~cfg_wr_en;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    lw_addr_r <= nl;
    lw_data_r <= wp_adv;
    p1_r      <= res;
  end

  llrb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_we),
    .wr_addr (write_pos_r),
    .wr_data (in_data_byte),
    .rd_addr (byte_raddr),
    .rd_data (byte_rdata)
  );

  llrb_ram #(
    .WIDTH (PW),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (nl),
    .wr_data (wp_adv),
    .rd_addr (ls_raddr_nxt),
    .rd_data (ls_rdata)
  );

  // byte ram data lines up with the item in the cycle after acceptance
  always_comb begin
    push_item.data   = (p1_r.status == llrb_pkg::ST_BYTE) ? byte_rdata : 8'h00;
    push_item.status = p1_r.status;
    push_item.last   = p1_r.last;
  end

  llrb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p1_valid_r),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .count     (q_count)
  );

  assign out_byte    = out_item.data;
  assign out_status  = out_item.status;
  assign out_is_last = out_item.last;

`ifndef SYNTHESIS
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= (llrb_pkg::CW+1)'(llrb_pkg::QUEUE_DEPTH))
    else $error("more items in flight than output queue slots");

  a_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_line_r <= n_eff_r) && (newest_line_r <= n_eff_r) && (write_pos_r <= LAST_POS))
    else $error("ring pointer outside its ring");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && in_accept && !cfg_wr_en && (in_opcode != llrb_pkg::OP_RESTART) |=> ovf_r)
    else $error("overflow cleared without restart");

  a_overflow_answer: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && in_accept && !cfg_wr_en &&
    ((in_opcode == llrb_pkg::OP_WRITE) || (in_opcode == llrb_pkg::OP_READ))
    |=> p1_valid_r && (p1_r.status == llrb_pkg::ST_OVERFLOW))
    else $error("item under overflow not answered with overflow");

  a_byte_only_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != llrb_pkg::ST_BYTE) |-> (out_byte == 8'h00) && !out_is_last)
    else $error("byte or last flag on a result that delivers no byte");
`endif

endmodule
